// File: hw/rtl/iawi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_pkg
// Types and codes shared by the indexed word array with insert.
// ----------------------------------------------------------------------------
package iawi_pkg;

  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_APPEND = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_INSERT = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // cells OR-ed together into one register of the read tree
  localparam int unsigned READ_GROUP = 16;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  index;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [8:0]  count;
  } rsp_t;

  typedef struct packed {
    logic wr_at_index;
    logic wr_at_count;
    logic ins;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/iawi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_cell
// One word of the array: loads a new word, takes its lower neighbour's word
// on an insert, and offers its word to the read tree when selected.
// ----------------------------------------------------------------------------
module iawi_cell #(
  parameter int unsigned CW  = 9,
  parameter int unsigned POS = 0
) (
  input  wire                    clk_i,
  input  iawi_pkg::cell_cmd_t    cmd_i,
  input  wire        [CW-1:0]    index_i,
  input  wire        [CW-1:0]    count_i,
  input  wire        [CW-1:0]    sel_i,
  input  wire        [31:0]      value_i,
  input  wire        [31:0]      prev_word_i,
  output logic       [31:0]      word_o,
  output logic       [31:0]      rd_word_o
);

  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic [31:0] word_q, word_d;
  logic        at_index, at_count, load, shift;

  assign at_index = (POS_C == index_i);
  assign at_count = (POS_C == count_i);
  assign load     = (cmd_i.wr_at_index && at_index) || (cmd_i.wr_at_count && at_count) ||
                    (cmd_i.ins && at_index);
  assign shift    = cmd_i.ins && (POS_C > index_i);

  always_comb begin
    word_d = word_q;
    if (load) begin
      word_d = value_i;
    end else if (shift) begin
      word_d = prev_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (POS_C == sel_i) ? word_q : 32'd0;

endmodule
`default_nettype wire

// File: hw/rtl/iawi_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_reduce
// Registered OR tree that collects the one selected cell word.
// ----------------------------------------------------------------------------
module iawi_reduce #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  [CAPACITY-1:0][31:0]    words_i,
  output logic [31:0]                  word_o
);

  localparam int unsigned G    = iawi_pkg::READ_GROUP;
  localparam int unsigned NGRP = (CAPACITY + G - 1) / G;

  logic [NGRP-1:0][31:0] group_q, group_d;

  always_comb begin
    group_d = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      for (int unsigned i = 0; i < G; i++) begin
        if (g * G + i < CAPACITY) begin
          group_d[g] = group_d[g] | words_i[g * G + i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      group_q <= group_d;
    end
  end

  always_comb begin
    word_o = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      word_o = word_o | group_q[g];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/indexed_array_with_insert_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_with_insert_top
// Bounded array of 32-bit words with read, write, append, remove-last and
// insert-at-index.
// ----------------------------------------------------------------------------
// A transaction passes a first stage and then the output register, and no new
// one is taken while the first stage is full: the words sit in a row of cells
// that all update in the acceptance cycle (an insert moves every later word up
// one cell at once), and a read or remove collects the chosen word through a
// registered OR tree over the row. Errors leave the array and count untouched.
// The result waits in an output register while the downstream side stalls.
// ----------------------------------------------------------------------------
module indexed_array_with_insert_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  iawi_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output iawi_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 accept, ok;
  logic [1:0]           status;
  logic                 rd_sel;
  logic [CW-1:0]        idx_ext, cnt_ext, sel;
  iawi_pkg::cell_cmd_t  cmd;

  logic                 s1_valid_q, s1_rd_q;
  logic [1:0]           s1_status_q;
  logic [8:0]           s1_count_q;
  logic                 out_valid_q;
  iawi_pkg::rsp_t       out_rsp_q;
  logic                 move;
  logic [31:0]          rd_word;

  logic [CAPACITY-1:0][31:0] words, rd_words;

  assign in_stall_o = s1_valid_q;
  assign accept     = in_valid_i && !s1_valid_q;
  assign idx_ext    = CW'(in_req_i.index);
  assign cnt_ext    = CW'(cnt_q);

  always_comb begin
    status = iawi_pkg::STATUS_OK;
    rd_sel = 1'b0;
    sel    = idx_ext;
    cnt_d  = cnt_q;
    case (in_req_i.mode)
      iawi_pkg::MODE_READ: begin
        if (idx_ext >= cnt_ext) status = iawi_pkg::STATUS_BAD_INDEX;
        else rd_sel = 1'b1;
      end
      iawi_pkg::MODE_WRITE: begin
        if (idx_ext >= cnt_ext) status = iawi_pkg::STATUS_BAD_INDEX;
      end
      iawi_pkg::MODE_APPEND: begin
        if (cnt_q == CAP_C) status = iawi_pkg::STATUS_FULL;
        else cnt_d = cnt_q + 1'b1;
      end
      iawi_pkg::MODE_REMOVE: begin
        sel = cnt_ext - 1'b1;
        if (cnt_q == '0) begin
          status = iawi_pkg::STATUS_EMPTY;
        end else begin
          rd_sel = 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      iawi_pkg::MODE_INSERT: begin
        if (idx_ext > cnt_ext) status = iawi_pkg::STATUS_BAD_INDEX;
        else if (cnt_q == CAP_C) status = iawi_pkg::STATUS_FULL;
        else cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign ok              = (status == iawi_pkg::STATUS_OK);
  assign cmd.wr_at_index = accept && ok && (in_req_i.mode == iawi_pkg::MODE_WRITE);
  assign cmd.wr_at_count = accept && ok && (in_req_i.mode == iawi_pkg::MODE_APPEND);
  assign cmd.ins         = accept && ok && (in_req_i.mode == iawi_pkg::MODE_INSERT);

  for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
    iawi_cell #(
      .CW  (CW),
      .POS (p)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .index_i     (idx_ext),
      .count_i     (cnt_ext),
      .sel_i       (sel),
      .value_i     (in_req_i.value),
      .prev_word_i ((p == 0) ? in_req_i.value : words[(p == 0) ? 0 : p - 1]),
      .word_o      (words[p]),
      .rd_word_o   (rd_words[p])
    );
  end

  iawi_reduce #(
    .CAPACITY (CAPACITY)
  ) u_reduce (
    .clk_i   (clk_i),
    .en_i    (accept),
    .words_i (rd_words),
    .word_o  (rd_word)
  );

  assign move = s1_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= rd_sel;
      s1_status_q <= status;
      s1_count_q  <= 9'(cnt_d);
    end
    if (move) begin
      out_rsp_q.read_data <= s1_rd_q ? rd_word : 32'd0;
      out_rsp_q.status    <= s1_status_q;
      out_rsp_q.count     <= s1_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
`default_nettype wire

// File: hw/rtl/iawi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_checker
// Port-level checks on the indexed word array, bound to the top level.
// ----------------------------------------------------------------------------
module iawi_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input iawi_pkg::rsp_t out_rsp_o
);

  localparam logic [8:0] CAP_LOW = 9'(CAPACITY);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // one transaction in flight at the front: the input stalls in the cycle after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction taken on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == iawi_pkg::STATUS_EMPTY |-> out_rsp_o.count == 9'd0)
    else $error("empty status with nonzero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == iawi_pkg::STATUS_FULL |-> out_rsp_o.count == CAP_LOW)
    else $error("full status with count below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != iawi_pkg::STATUS_OK |-> out_rsp_o.read_data == 32'd0)
    else $error("read data on an error");

endmodule

bind indexed_array_with_insert_top iawi_checker #(
  .CAPACITY (CAPACITY)
) u_iawi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed word array with insert. A short table
// of directed rows covers bad-index and empty errors, unused modes and the
// insert shift; random traffic then fills the array to capacity and drains it
// again. Responses are compared field by field with a shadow array or typed rows.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY   = 256;
  localparam int          RAND_ITEMS = 600;
  localparam int          LONG_HOLD  = 60;
  localparam int          IDLE_LIMIT = 4000;

  typedef struct {
    iawi_pkg::req_t req;
    bit             typed;
    iawi_pkg::rsp_t rsp;
  } row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  iawi_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_stall_i;
  iawi_pkg::rsp_t out_rsp_o;

  logic [31:0]    shadow_words [CAPACITY];
  int             shadow_fill;
  iawi_pkg::rsp_t pending_rsp [$];
  row_t           directed_rows [$];
  iawi_pkg::rsp_t want;

  int err_count;
  int items_sent;
  int rsp_seen;
  int n_bad_index;
  int n_empty;
  int n_full;
  bit quiet_tail;
  bit hold_off_req;
  bit growing;
  bit reached_full;
  bit reached_empty;

  indexed_array_with_insert_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // shadow of the array: applies one request and returns its response
  function automatic iawi_pkg::rsp_t array_response(input iawi_pkg::req_t req);
    iawi_pkg::rsp_t rsp;
    int             j;
    rsp.read_data = '0;
    rsp.status    = iawi_pkg::STATUS_OK;
    case (req.mode)
      iawi_pkg::MODE_READ: begin
        if (req.index >= shadow_fill) rsp.status = iawi_pkg::STATUS_BAD_INDEX;
        else rsp.read_data = shadow_words[req.index];
      end
      iawi_pkg::MODE_WRITE: begin
        if (req.index >= shadow_fill) rsp.status = iawi_pkg::STATUS_BAD_INDEX;
        else shadow_words[req.index] = req.value;
      end
      iawi_pkg::MODE_APPEND: begin
        if (shadow_fill >= CAPACITY) rsp.status = iawi_pkg::STATUS_FULL;
        else begin
          shadow_words[shadow_fill] = req.value;
          shadow_fill++;
        end
      end
      iawi_pkg::MODE_REMOVE: begin
        if (shadow_fill == 0) rsp.status = iawi_pkg::STATUS_EMPTY;
        else begin
          shadow_fill--;
          rsp.read_data = shadow_words[shadow_fill];
        end
      end
      iawi_pkg::MODE_INSERT: begin
        if (req.index > shadow_fill) rsp.status = iawi_pkg::STATUS_BAD_INDEX;
        else if (shadow_fill >= CAPACITY) rsp.status = iawi_pkg::STATUS_FULL;
        else begin
          for (j = shadow_fill; j > req.index; j--) shadow_words[j] = shadow_words[j - 1];
          shadow_words[req.index] = req.value;
          shadow_fill++;
        end
      end
      default: ;
    endcase
    rsp.count = 9'(shadow_fill);
    return rsp;
  endfunction

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // index below the given bound, or anywhere if the bound is zero
  function automatic logic [7:0] index_below(input int bound);
    if (bound <= 0) return 8'($urandom_range(0, 255));
    if (bound > 256) bound = 256;
    return 8'($urandom_range(0, bound - 1));
  endfunction

  task automatic add_row(input logic [2:0] mode, input logic [7:0] index,
                         input logic [31:0] value, input bit typed,
                         input logic [31:0] rd, input logic [1:0] st,
                         input logic [8:0] cnt);
    row_t row;
    row.req.mode      = mode;
    row.req.index     = index;
    row.req.value     = value;
    row.typed         = typed;
    row.rsp.read_data = rd;
    row.rsp.status    = st;
    row.rsp.count     = cnt;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic send_req(input iawi_pkg::req_t req, input bit typed,
                          input iawi_pkg::rsp_t typed_rsp);
    iawi_pkg::rsp_t predicted;
    int             gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = array_response(req);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  task automatic next_random_req(output iawi_pkg::req_t req);
    int pick;
    pick      = $urandom_range(0, 99);
    req.mode  = iawi_pkg::MODE_READ;
    req.index = index_below(shadow_fill);
    req.value = rand_word();
    if (growing) begin
      if (pick < 45) req.mode = iawi_pkg::MODE_APPEND;
      else if (pick < 70) begin
        req.mode  = iawi_pkg::MODE_INSERT;
        req.index = index_below(shadow_fill + 1);
      end
      else if (pick < 80) req.mode = iawi_pkg::MODE_READ;
      else if (pick < 88) req.mode = iawi_pkg::MODE_WRITE;
      else if (pick < 92) req.mode = iawi_pkg::MODE_REMOVE;
      else pick = -1;
    end else begin
      if (pick < 65) req.mode = iawi_pkg::MODE_REMOVE;
      else if (pick < 75) req.mode = iawi_pkg::MODE_READ;
      else if (pick < 85) req.mode = iawi_pkg::MODE_WRITE;
      else if (pick < 90) begin
        req.mode  = iawi_pkg::MODE_INSERT;
        req.index = index_below(shadow_fill + 1);
      end
      else if (pick < 92) req.mode = iawi_pkg::MODE_APPEND;
      else pick = -1;
    end
    // noise: any mode, any index
    if (pick < 0) begin
      req.mode  = 3'($urandom_range(0, 7));
      req.index = 8'($urandom_range(0, 255));
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_rsp_o), 32'h0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.read_data !== want.read_data)
          report_mismatch("read_data", out_rsp_o.read_data, want.read_data);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (out_rsp_o.count !== want.count)
          report_mismatch("count", 32'(out_rsp_o.count), 32'(want.count));
        case (want.status)
          iawi_pkg::STATUS_BAD_INDEX: n_bad_index++;
          iawi_pkg::STATUS_EMPTY:     n_empty++;
          iawi_pkg::STATUS_FULL:      n_full++;
          default: ;
        endcase
      end
    end
  end

  // receiver back-pressure
  initial begin : rx_stall
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        n = 1;
        while (n < LONG_HOLD) begin
          @(negedge clk_i);
          n++;
        end
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet_tail) begin
          n = $urandom_range(1, 7);
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, %0d responses outstanding", $time, pending_rsp.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    iawi_pkg::req_t req;
    int             k;
    int             dwell;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    shadow_fill = 0;
    growing     = 1'b1;
    dwell       = 0;
    for (k = 0; k < CAPACITY; k++) shadow_words[k] = '0;

    // mode, index, value, typed, read_data, status, count
    add_row(iawi_pkg::MODE_READ,   8'd0,   32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd0);
    add_row(iawi_pkg::MODE_REMOVE, 8'd0,   32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_EMPTY,     9'd0);
    add_row(iawi_pkg::MODE_WRITE,  8'd0,   32'hFFFF_FFFF, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd0);
    add_row(iawi_pkg::MODE_INSERT, 8'd1,   32'hFFFF_FFFF, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd0);
    add_row(3'd5,                  8'd0,   32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(3'd6,                  8'd128, 32'h5555_5555, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(3'd7,                  8'd255, 32'hFFFF_FFFF, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(iawi_pkg::MODE_INSERT, 8'd0,   32'hFFFF_FFFF, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd1);
    add_row(iawi_pkg::MODE_APPEND, 8'd255, 32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd2);
    add_row(iawi_pkg::MODE_APPEND, 8'd0,   32'h8000_0001, 1, 32'h0,
            iawi_pkg::STATUS_OK,        9'd3);
    add_row(iawi_pkg::MODE_INSERT, 8'd0,   32'h1234_5678, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(iawi_pkg::MODE_INSERT, 8'd2,   32'hA5A5_A5A5, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    for (k = 0; k < 5; k++)
      add_row(iawi_pkg::MODE_READ, 8'(k),  32'h0000_0000, 0, 32'h0,
              iawi_pkg::STATUS_OK,      9'd0);
    add_row(iawi_pkg::MODE_WRITE,  8'd4,   32'hDEAD_BEEF, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(iawi_pkg::MODE_WRITE,  8'd5,   32'h0000_0001, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd5);
    add_row(iawi_pkg::MODE_READ,   8'd255, 32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd5);
    add_row(iawi_pkg::MODE_INSERT, 8'd6,   32'h0000_0000, 1, 32'h0,
            iawi_pkg::STATUS_BAD_INDEX, 9'd5);
    add_row(iawi_pkg::MODE_REMOVE, 8'd0,   32'h0000_0000, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(iawi_pkg::MODE_REMOVE, 8'd0,   32'h0000_0000, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);
    add_row(iawi_pkg::MODE_READ,   8'd2,   32'h0000_0000, 0, 32'h0,
            iawi_pkg::STATUS_OK,        9'd0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) send_req(directed_rows[r].req, directed_rows[r].typed,
                                        directed_rows[r].rsp);

    // random phase: grow to capacity, dwell on the full errors, drain to empty
    for (k = 0; (k < RAND_ITEMS || !reached_full) && k < 4 * RAND_ITEMS; k++) begin
      if (k == 150) hold_off_req = 1'b1;
      if (k == 300) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk_i);
      end
      if (k >= RAND_ITEMS - 80) quiet_tail = 1'b1;
      next_random_req(req);
      send_req(req, 1'b0, '0);
      if (growing && shadow_fill == CAPACITY) begin
        reached_full = 1'b1;
        if (++dwell > 10) begin
          growing = 1'b0;
          dwell   = 0;
        end
      end else if (!growing && shadow_fill == 0) begin
        reached_empty = 1'b1;
        if (++dwell > 6) begin
          growing = 1'b1;
          dwell   = 0;
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $display("%0d responses never arrived", pending_rsp.size());
      err_count++;
    end

    $display("%0d requests, %0d responses, %0d mismatches", items_sent, rsp_seen, err_count);
    $display("error responses: %0d bad index, %0d empty, %0d full; filled %0b, drained %0b",
             n_bad_index, n_empty, n_full, reached_full, reached_empty);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: indexed_array_with_insert_top.f
hw/rtl/iawi_pkg.sv
hw/rtl/iawi_cell.sv
hw/rtl/iawi_reduce.sv
hw/rtl/indexed_array_with_insert_top.sv
hw/rtl/iawi_checker.sv
sim/testbench.sv
